FILE: hdl/opbc_pkg.sv
// opbc_pkg: shared types, constants and tick conversion helpers for the
// output pulse/blink controller. No dependencies; every other file in hdl/
// refers to it by scoped names.
package opbc_pkg;

    // default parameter values
    localparam int NUM_OUTPUTS_DEF = 16;
    localparam int TICK_MS_DEF     = 100;

    // field widths of the request and response payloads
    localparam int REQ_W     = 3;
    localparam int CHAN_W    = 4;
    localparam int PHASE_MS_W = 16;
    localparam int OPER_MS_W = 32;
    localparam int LEVELS_W  = 16;

    // per-line state widths
    localparam int MODE_W  = 2;
    localparam int PHASE_W = 10;
    localparam int OPER_W  = 26;

    // millisecond to tick converter: three lanes of 32-bit dividends
    localparam int DIV_W      = 32;
    localparam int DIV_LANES  = 3;
    localparam int LANE_OPER  = 0;
    localparam int LANE_HIGH  = 1;
    localparam int LANE_LOW   = 2;

    localparam int PHASE_MAX = (1 << PHASE_W) - 1;
    localparam int OPER_MAX  = (1 << OPER_W) - 1;
    localparam logic [DIV_W-1:0] PHASE_LIM = DIV_W'(PHASE_MAX);
    localparam logic [DIV_W-1:0] OPER_LIM  = DIV_W'(OPER_MAX);

    // request codes
    typedef logic [REQ_W-1:0] req_code_t;
    localparam req_code_t REQ_TICK   = 3'd0;
    localparam req_code_t REQ_SET    = 3'd1;
    localparam req_code_t REQ_TOGGLE = 3'd2;
    localparam req_code_t REQ_PULSE  = 3'd3;
    localparam req_code_t REQ_BLINK  = 3'd4;

    // line modes
    typedef logic [MODE_W-1:0] mode_t;
    localparam mode_t MODE_SET   = 2'd0;
    localparam mode_t MODE_PULSE = 2'd1;
    localparam mode_t MODE_BLINK = 2'd2;

    // timer memory entry
    typedef struct packed {
        mode_t               mode;
        logic [PHASE_W-1:0]  phase;
        logic [OPER_W-1:0]   oper;
    } timer_ent_t;

    // blink period memory entry
    typedef struct packed {
        logic [PHASE_W-1:0]  high_ticks;
        logic [PHASE_W-1:0]  low_ticks;
    } period_ent_t;

    typedef logic [DIV_LANES-1:0][DIV_W-1:0] div_lanes_t;

    // quotient plus one, saturated to the phase timer width
    function automatic logic [PHASE_W-1:0] phase_ticks(input logic [DIV_W-1:0] q);
        logic [PHASE_W-1:0] res;
        if (q >= PHASE_LIM)
            res = '1;
        else
            res = q[PHASE_W-1:0] + PHASE_W'(1);
        return res;
    endfunction

    // quotient plus one, saturated to the operation timer width
    function automatic logic [OPER_W-1:0] oper_ticks(input logic [DIV_W-1:0] q);
        logic [OPER_W-1:0] res;
        if (q >= OPER_LIM)
            res = '1;
        else
            res = q[OPER_W-1:0] + OPER_W'(1);
        return res;
    endfunction

endpackage

FILE: hdl/opbc_if.sv
// opbc_if: valid/ready channel interfaces for the request and response
// sides of the output pulse/blink controller. Depends on opbc_pkg.
interface opbc_req_if;
    logic                              valid;
    logic                              ready;
    logic [opbc_pkg::REQ_W-1:0]        req_type;
    logic [opbc_pkg::CHAN_W-1:0]       channel;
    logic                              level;
    logic [opbc_pkg::PHASE_MS_W-1:0]   high_ms;
    logic [opbc_pkg::PHASE_MS_W-1:0]   low_ms;
    logic [opbc_pkg::OPER_MS_W-1:0]    oper_ms;

    modport source (output valid, req_type, channel, level, high_ms, low_ms, oper_ms,
                    input ready);
    modport sink   (input valid, req_type, channel, level, high_ms, low_ms, oper_ms,
                    output ready);
endinterface

interface opbc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [opbc_pkg::LEVELS_W-1:0]     levels;

    modport source (output valid, levels, input ready);
    modport sink   (input valid, levels, output ready);
endinterface

FILE: hdl/output_pulse_blink_controller_core.sv
// output_pulse_blink_controller_core: top level of the output pulse/blink
// controller. Depends on opbc_pkg, opbc_if, opbc_divider, opbc_state_mem
// and opbc_tick_logic.
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+------------------------------------------
//   req     | in  | valid/ready | req_type, channel, level, high_ms,
//           |     |             | low_ms, oper_ms
//   rsp     | out | valid/ready | levels
//
// One request at a time. A tick walks the timer memory one line per cycle,
// read then write back; pulse and blink wait in ST_DIV for the ms-to-tick
// multiply, then go through ST_EXEC; set and toggle go through ST_EXEC only;
// unknown or out-of-range requests go from ST_IDLE straight to ST_DONE.
// Reset clears the line levels and the memory valid bits at once.
// A stalled response holds in the output register; the next request is
// taken meanwhile and its result waits until the register frees.
module output_pulse_blink_controller_core #(
    parameter int NUM_OUTPUTS = opbc_pkg::NUM_OUTPUTS_DEF,
    parameter int TICK_MS     = opbc_pkg::TICK_MS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    opbc_req_if.sink     req,
    opbc_rsp_if.source   rsp
);

    localparam int AW    = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam int CW    = $clog2(NUM_OUTPUTS + 1);
    localparam int PAD_W = (NUM_OUTPUTS > opbc_pkg::LEVELS_W) ? NUM_OUTPUTS
                                                             : opbc_pkg::LEVELS_W;
    localparam logic [CW-1:0] SCAN_END = CW'(NUM_OUTPUTS);

    // controller states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_TICK = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    opbc_pkg::req_code_t          rtype_reg;
    logic [AW-1:0]                chan_reg;
    logic                         lvl_reg;
    logic                         op_zero_reg;
    logic [NUM_OUTPUTS-1:0]       line_level_reg;
    logic [NUM_OUTPUTS-1:0]       line_level_next;
    logic [CW-1:0]                rd_cnt_reg;
    logic                         rd_pend_reg;
    logic [AW-1:0]                wb_addr_reg;
    logic                         out_valid_reg;
    logic [opbc_pkg::LEVELS_W-1:0] levels_reg;

    logic                         accept;
    logic                         in_range;
    logic                         div_start;
    logic                         div_done;
    opbc_pkg::div_lanes_t         div_dvd;
    opbc_pkg::div_lanes_t         div_q;
    logic                         rd_en;
    logic                         out_free;
    logic [AW-1:0]                wr_addr;
    logic                         tm_we;
    logic                         pd_we;
    opbc_pkg::timer_ent_t         tm_wdata;
    opbc_pkg::period_ent_t        pd_wdata;
    opbc_pkg::timer_ent_t         rd_timer;
    opbc_pkg::period_ent_t        rd_period;
    opbc_pkg::timer_ent_t         tick_timer;
    logic                         tick_lvl;
    logic [PAD_W-1:0]             lvl_pad;

    // request acceptance
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign in_range  = int'(req.channel) < NUM_OUTPUTS;
    assign div_start = accept && in_range &&
                       ((req.req_type == opbc_pkg::REQ_PULSE) ||
                        (req.req_type == opbc_pkg::REQ_BLINK));
    assign out_free  = !out_valid_reg || rsp.ready;

    // millisecond to tick conversion lanes
    always_comb
    begin
        div_dvd                     = '0;
        div_dvd[opbc_pkg::LANE_OPER] = req.oper_ms;
        div_dvd[opbc_pkg::LANE_HIGH] = opbc_pkg::DIV_W'(req.high_ms);
        div_dvd[opbc_pkg::LANE_LOW]  = opbc_pkg::DIV_W'(req.low_ms);
    end

    opbc_divider #(
        .TICK_MS (TICK_MS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .quotient (div_q),
        .done     (div_done)
    );

    // next controller state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        opbc_pkg::REQ_TICK:   state_next = ST_TICK;
                        opbc_pkg::REQ_SET,
                        opbc_pkg::REQ_TOGGLE: state_next = in_range ? ST_EXEC : ST_DONE;
                        opbc_pkg::REQ_PULSE,
                        opbc_pkg::REQ_BLINK:  state_next = in_range ? ST_DIV : ST_DONE;
                        default:              state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
                state_next = ST_DONE;
            ST_TICK:
            begin
                if ((rd_cnt_reg == SCAN_END) && !rd_pend_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // scan read issue
    assign rd_en = (state_reg == ST_TICK) && (rd_cnt_reg != SCAN_END);

    opbc_state_mem #(
        .DEPTH (NUM_OUTPUTS),
        .AW    (AW)
    ) u_state_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (rd_cnt_reg[AW-1:0]),
        .rd_timer  (rd_timer),
        .rd_period (rd_period),
        .wr_addr   (wr_addr),
        .tm_we     (tm_we),
        .tm_wdata  (tm_wdata),
        .pd_we     (pd_we),
        .pd_wdata  (pd_wdata)
    );

    opbc_tick_logic u_tick_logic (
        .cur     (rd_timer),
        .per     (rd_period),
        .lvl_in  (line_level_reg[wb_addr_reg]),
        .nxt     (tick_timer),
        .lvl_out (tick_lvl)
    );

    // memory writes and line level updates
    always_comb
    begin
        wr_addr         = chan_reg;
        tm_we           = 1'b0;
        pd_we           = 1'b0;
        tm_wdata        = '0;
        pd_wdata        = '0;
        line_level_next = line_level_reg;
        if ((state_reg == ST_TICK) && rd_pend_reg)
        begin
            wr_addr                      = wb_addr_reg;
            tm_we                        = 1'b1;
            tm_wdata                     = tick_timer;
            line_level_next[wb_addr_reg] = tick_lvl;
        end
        else if (state_reg == ST_EXEC)
        begin
            case (rtype_reg)
                opbc_pkg::REQ_SET:
                begin
                    tm_we                     = 1'b1;
                    tm_wdata.mode             = opbc_pkg::MODE_SET;
                    line_level_next[chan_reg] = lvl_reg;
                end
                opbc_pkg::REQ_TOGGLE:
                begin
                    tm_we                     = 1'b1;
                    tm_wdata.mode             = opbc_pkg::MODE_SET;
                    line_level_next[chan_reg] = ~line_level_reg[chan_reg];
                end
                opbc_pkg::REQ_PULSE:
                begin
                    tm_we                     = 1'b1;
                    tm_wdata.mode             = opbc_pkg::MODE_PULSE;
                    tm_wdata.oper = opbc_pkg::oper_ticks(div_q[opbc_pkg::LANE_OPER]);
                    line_level_next[chan_reg] = lvl_reg;
                end
                opbc_pkg::REQ_BLINK:
                begin
                    tm_we                     = 1'b1;
                    pd_we                     = 1'b1;
                    tm_wdata.mode             = opbc_pkg::MODE_BLINK;
                    tm_wdata.phase = opbc_pkg::phase_ticks(div_q[opbc_pkg::LANE_HIGH]);
                    tm_wdata.oper  = op_zero_reg ? '0 :
                                     opbc_pkg::oper_ticks(div_q[opbc_pkg::LANE_OPER]);
                    pd_wdata.high_ticks = opbc_pkg::phase_ticks(div_q[opbc_pkg::LANE_HIGH]);
                    pd_wdata.low_ticks  = opbc_pkg::phase_ticks(div_q[opbc_pkg::LANE_LOW]);
                    line_level_next[chan_reg] = 1'b1;
                end
                default:
                begin
                    tm_we = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            line_level_reg <= '0;
            rd_cnt_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            line_level_reg <= line_level_next;
            rd_pend_reg    <= rd_en;
            if (accept)
                rd_cnt_reg <= '0;
            else if (rd_en)
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // captured request fields, scan write-back address, result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rtype_reg   <= req.req_type;
            chan_reg    <= AW'(req.channel);
            lvl_reg     <= req.level;
            op_zero_reg <= (req.oper_ms == '0);
        end
        if (rd_en)
            wb_addr_reg <= rd_cnt_reg[AW-1:0];
        if ((state_reg == ST_DONE) && out_free)
            levels_reg <= lvl_pad[opbc_pkg::LEVELS_W-1:0];
    end

    assign lvl_pad    = PAD_W'(line_level_reg);
    assign rsp.valid  = out_valid_reg;
    assign rsp.levels = levels_reg;

endmodule

FILE: hdl/opbc_divider.sv
// opbc_divider: three-lane divide by the constant tick length, a reciprocal
// multiply split into low and high dividend halves, low half first.
// Depends on opbc_pkg.
module opbc_divider #(
    parameter int TICK_MS = opbc_pkg::TICK_MS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  opbc_pkg::div_lanes_t dividend,
    output opbc_pkg::div_lanes_t quotient,
    output logic                 done
);

    localparam int HALF_W = opbc_pkg::DIV_W / 2;
    localparam int MUL_W  = opbc_pkg::DIV_W + 1;
    localparam int PROD_W = HALF_W + MUL_W;
    localparam int SUM_W  = opbc_pkg::DIV_W + MUL_W;
    localparam int SHIFT  = opbc_pkg::DIV_W + $clog2(TICK_MS);
    // reciprocal rounded up, exact quotient for every 32-bit dividend
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_FULL);

    opbc_pkg::div_lanes_t                        dvd_reg;
    logic [opbc_pkg::DIV_LANES-1:0][PROD_W-1:0] plo_reg;
    logic [opbc_pkg::DIV_LANES-1:0][PROD_W-1:0] plo_next;
    logic [opbc_pkg::DIV_LANES-1:0][SUM_W-1:0]  sum;
    opbc_pkg::div_lanes_t                        q_reg;
    opbc_pkg::div_lanes_t                        q_next;
    logic                                        lo_step_reg;
    logic                                        hi_step_reg;
    logic                                        done_reg;

    // low half product, then high half product plus the low one
    always_comb
    begin
        for (int l = 0; l < opbc_pkg::DIV_LANES; l++)
        begin
            plo_next[l] = PROD_W'(dvd_reg[l][HALF_W-1:0]) * PROD_W'(RECIP);
            sum[l]      = {PROD_W'(dvd_reg[l][opbc_pkg::DIV_W-1:HALF_W]) * PROD_W'(RECIP),
                           HALF_W'(0)} + SUM_W'(plo_reg[l]);
            q_next[l]   = opbc_pkg::DIV_W'(sum[l] >> SHIFT);
        end
    end

    // step sequence: start, low step, high step, then done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_step_reg <= 1'b0;
            hi_step_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            lo_step_reg <= start;
            hi_step_reg <= lo_step_reg;
            done_reg    <= hi_step_reg;
        end
    end

    // dividend, partial product and quotient registers
    always_ff @(posedge clk)
    begin
        if (start)
            dvd_reg <= dividend;
        if (lo_step_reg)
            plo_reg <= plo_next;
        if (hi_step_reg)
            q_reg <= q_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

FILE: hdl/opbc_state_mem.sv
// opbc_state_mem: per-line timer and blink period memories, registered
// read, with per-entry valid bits so unwritten entries read zero.
// Depends on opbc_pkg.
module opbc_state_mem #(
    parameter int DEPTH = opbc_pkg::NUM_OUTPUTS_DEF,
    parameter int AW    = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output opbc_pkg::timer_ent_t  rd_timer,
    output opbc_pkg::period_ent_t rd_period,
    input  logic [AW-1:0]         wr_addr,
    input  logic                  tm_we,
    input  opbc_pkg::timer_ent_t  tm_wdata,
    input  logic                  pd_we,
    input  opbc_pkg::period_ent_t pd_wdata
);

    opbc_pkg::timer_ent_t  tmem [DEPTH];
    opbc_pkg::period_ent_t pmem [DEPTH];
    logic [DEPTH-1:0]      tvld_reg;
    logic [DEPTH-1:0]      pvld_reg;
    opbc_pkg::timer_ent_t  tq_reg;
    opbc_pkg::period_ent_t pq_reg;
    logic                  tq_vld_reg;
    logic                  pq_vld_reg;

    // memory arrays: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (tm_we)
            tmem[wr_addr] <= tm_wdata;
        if (pd_we)
            pmem[wr_addr] <= pd_wdata;
        if (rd_en)
        begin
            tq_reg <= tmem[rd_addr];
            pq_reg <= pmem[rd_addr];
        end
    end

    // entry valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvld_reg   <= '0;
            pvld_reg   <= '0;
            tq_vld_reg <= 1'b0;
            pq_vld_reg <= 1'b0;
        end
        else
        begin
            if (tm_we)
                tvld_reg[wr_addr] <= 1'b1;
            if (pd_we)
                pvld_reg[wr_addr] <= 1'b1;
            if (rd_en)
            begin
                tq_vld_reg <= tvld_reg[rd_addr];
                pq_vld_reg <= pvld_reg[rd_addr];
            end
        end
    end

    // an entry never written reads as its reset value
    assign rd_timer  = tq_vld_reg ? tq_reg : '0;
    assign rd_period = pq_vld_reg ? pq_reg : '0;

endmodule

FILE: hdl/opbc_tick_logic.sv
// opbc_tick_logic: next state of one line on a tick (decrement, phase
// expiry, operation expiry). Depends on opbc_pkg.
module opbc_tick_logic (
    input  opbc_pkg::timer_ent_t  cur,
    input  opbc_pkg::period_ent_t per,
    input  logic                  lvl_in,
    output opbc_pkg::timer_ent_t  nxt,
    output logic                  lvl_out
);

    logic [opbc_pkg::PHASE_W-1:0] ph_dec;
    logic [opbc_pkg::OPER_W-1:0]  op_dec;

    // timers above one count down
    always_comb
    begin
        ph_dec = (cur.phase > opbc_pkg::PHASE_W'(1)) ? cur.phase - opbc_pkg::PHASE_W'(1)
                                                      : cur.phase;
        op_dec = (cur.oper > opbc_pkg::OPER_W'(1)) ? cur.oper - opbc_pkg::OPER_W'(1)
                                                    : cur.oper;
    end

    // phase expiry first, then operation expiry
    always_comb
    begin
        nxt     = cur;
        nxt.phase = ph_dec;
        nxt.oper  = op_dec;
        lvl_out = lvl_in;
        if ((ph_dec == opbc_pkg::PHASE_W'(1)) && (cur.mode == opbc_pkg::MODE_BLINK))
        begin
            nxt.phase = lvl_in ? per.low_ticks : per.high_ticks;
            lvl_out   = ~lvl_in;
        end
        if (op_dec == opbc_pkg::OPER_W'(1))
        begin
            lvl_out   = ~lvl_out;
            nxt.phase = '0;
            nxt.oper  = '0;
            nxt.mode  = opbc_pkg::MODE_SET;
        end
    end

endmodule

FILE: hdl/opbc_checker.sv
// opbc_checker: port-level assertions for the output pulse/blink controller
// and the bind that attaches them to its top level. Depends on opbc_pkg.
module opbc_checker #(
    parameter int NUM_OUTPUTS = opbc_pkg::NUM_OUTPUTS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic [opbc_pkg::REQ_W-1:0]        req_type,
    input logic [opbc_pkg::CHAN_W-1:0]       req_channel,
    input logic                              req_level,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [opbc_pkg::LEVELS_W-1:0]     rsp_levels
);

    // one request at a time: ready drops after every accepted request
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another was in flight");

    // a set request with an empty output shows its level in the following response
    a_set_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_type == opbc_pkg::REQ_SET) &&
         (int'(req_channel) < NUM_OUTPUTS) && !rsp_valid)
        |-> ##3 (rsp_valid && (rsp_levels[$past(req_channel, 3)] == $past(req_level, 3))))
        else $error("set request result missing or wrong");

    // a stalled response stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response withdrawn while stalled");

    // a stalled response keeps its levels
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> $stable(rsp_levels))
        else $error("response levels changed while stalled");

endmodule

bind output_pulse_blink_controller_core opbc_checker #(
    .NUM_OUTPUTS (NUM_OUTPUTS)
) u_opbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_type    (req.req_type),
    .req_channel (req.channel),
    .req_level   (req.level),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_levels  (rsp.levels)
);

FILE: test/output_pulse_blink_controller_core_test.sv
// output_pulse_blink_controller_core_test: self-checking bench for the output
// pulse/blink controller, checked against an in-bench line-state predictor.
// Depends on opbc_pkg, opbc_if and the hdl core.
`timescale 1ns / 1ps

module output_pulse_blink_controller_core_test;

    localparam int LINES    = opbc_pkg::NUM_OUTPUTS_DEF;
    localparam int TICK_LEN = opbc_pkg::TICK_MS_DEF;

    // short names for the request codes
    localparam opbc_pkg::req_code_t C_TICK   = opbc_pkg::REQ_TICK;
    localparam opbc_pkg::req_code_t C_SET    = opbc_pkg::REQ_SET;
    localparam opbc_pkg::req_code_t C_TOGGLE = opbc_pkg::REQ_TOGGLE;
    localparam opbc_pkg::req_code_t C_PULSE  = opbc_pkg::REQ_PULSE;
    localparam opbc_pkg::req_code_t C_BLINK  = opbc_pkg::REQ_BLINK;

    // request codes the block does not decode
    localparam opbc_pkg::req_code_t REQ_SPARE5 = 3'd5;
    localparam opbc_pkg::req_code_t REQ_SPARE6 = 3'd6;
    localparam opbc_pkg::req_code_t REQ_SPARE7 = 3'd7;

    typedef struct packed {
        opbc_pkg::req_code_t                 kind;
        logic [opbc_pkg::CHAN_W-1:0]         chan;
        logic                                lvl;
        logic [opbc_pkg::PHASE_MS_W-1:0]     hi_ms;
        logic [opbc_pkg::PHASE_MS_W-1:0]     lo_ms;
        logic [opbc_pkg::OPER_MS_W-1:0]      op_ms;
    } line_cmd_t;

    typedef struct packed {
        line_cmd_t                           cmd;
        logic                                fixed;
        logic [opbc_pkg::LEVELS_W-1:0]       want;
    } directed_row_t;

    // directed requests; fixed rows carry a hand-worked levels value
    localparam directed_row_t DIRECTED_ROWS [0:24] = '{
        '{'{C_TICK,     4'd0,  1'b0, 16'd0,     16'd0,     32'd0},          1'b1, 16'h0000},
        '{'{C_SET,      4'd0,  1'b1, 16'd0,     16'd0,     32'd0},          1'b1, 16'h0001},
        '{'{C_SET,      4'd15, 1'b1, 16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF},  1'b1, 16'h8001},
        '{'{C_TOGGLE,   4'd15, 1'b0, 16'd0,     16'd0,     32'd0},          1'b1, 16'h0001},
        '{'{C_TOGGLE,   4'd7,  1'b1, 16'h5A5A,  16'hA5A5,  32'h1234_5678},  1'b1, 16'h0081},
        '{'{REQ_SPARE5, 4'd3,  1'b1, 16'd100,   16'd100,   32'd100},        1'b1, 16'h0081},
        '{'{REQ_SPARE6, 4'd15, 1'b1, 16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF},  1'b1, 16'h0081},
        '{'{REQ_SPARE7, 4'd0,  1'b0, 16'd0,     16'd0,     32'd0},          1'b1, 16'h0081},
        '{'{C_PULSE,    4'd1,  1'b1, 16'd0,     16'd0,     32'd0},          1'b1, 16'h0083},
        '{'{C_TICK,     4'd9,  1'b1, 16'hFFFF,  16'd0,     32'd0},          1'b1, 16'h0081},
        '{'{C_PULSE,    4'd2,  1'b0, 16'd0,     16'd0,     32'd150},        1'b1, 16'h0081},
        '{'{C_BLINK,    4'd4,  1'b0, 16'd0,     16'd0,     32'd0},          1'b1, 16'h0091},
        '{'{C_BLINK,    4'd10, 1'b0, 16'd0,     16'd0,     32'd50},         1'b1, 16'h0491},
        '{'{C_TICK,     4'd0,  1'b0, 16'd0,     16'd0,     32'd0},          1'b0, 16'h0000},
        '{'{C_BLINK,    4'd5,  1'b0, 16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF},  1'b0, 16'h0000},
        '{'{C_PULSE,    4'd8,  1'b1, 16'd0,     16'd0,     32'hFFFF_FFFF},  1'b0, 16'h0000},
        '{'{C_BLINK,    4'd6,  1'b1, 16'd100,   16'd250,   32'd1000},       1'b0, 16'h0000},
        '{'{C_TICK,     4'd0,  1'b0, 16'd0,     16'd0,     32'd0},          1'b0, 16'h0000},
        '{'{C_TICK,     4'd0,  1'b0, 16'd0,     16'd0,     32'd0},          1'b0, 16'h0000},
        '{'{C_TICK,     4'd0,  1'b0, 16'd0,     16'd0,     32'd0},          1'b0, 16'h0000},
        '{'{C_TICK,     4'd0,  1'b0, 16'd0,     16'd0,     32'd0},          1'b0, 16'h0000},
        '{'{C_SET,      4'd4,  1'b0, 16'd0,     16'd0,     32'd0},          1'b0, 16'h0000},
        '{'{C_PULSE,    4'd9,  1'b0, 16'd0,     16'd0,     32'd65535},      1'b0, 16'h0000},
        '{'{C_TOGGLE,   4'd5,  1'b0, 16'd0,     16'd0,     32'd0},          1'b0, 16'h0000},
        '{'{C_TICK,     4'd0,  1'b0, 16'd0,     16'd0,     32'd0},          1'b0, 16'h0000}
    };

    logic clk;
    logic rst_n;

    opbc_req_if req_ch ();
    opbc_rsp_if rsp_ch ();

    output_pulse_blink_controller_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted line state
    logic                             line_lvl  [LINES];
    opbc_pkg::mode_t                  line_md   [LINES];
    logic [opbc_pkg::PHASE_W-1:0]     phase_cnt [LINES];
    logic [opbc_pkg::OPER_W-1:0]      oper_cnt  [LINES];
    logic [opbc_pkg::PHASE_W-1:0]     blink_hi  [LINES];
    logic [opbc_pkg::PHASE_W-1:0]     blink_lo  [LINES];

    logic [opbc_pkg::LEVELS_W-1:0]    expected_levels [$];
    logic [opbc_pkg::LEVELS_W-1:0]    want_levels;
    int                               errors;
    bit                               calm_phase;
    int                               ready_hold;

    // ms to ticks, quotient plus one, saturated at the timer limit
    function automatic logic [31:0] ms_to_ticks(input logic [31:0] ms,
                                                input logic [31:0] limit);
        logic [32:0] t;
        t = {1'b0, ms} / 33'(TICK_LEN) + 33'd1;
        return (t > {1'b0, limit}) ? limit : t[31:0];
    endfunction

    // apply one request to the predicted state, return the resulting levels
    function automatic logic [opbc_pkg::LEVELS_W-1:0] apply_request(input line_cmd_t cmd);
        logic [opbc_pkg::LEVELS_W-1:0] lv;
        int c;
        c = int'(cmd.chan);
        if (cmd.kind == opbc_pkg::REQ_TICK)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                if (phase_cnt[i] > 1)
                    phase_cnt[i] = phase_cnt[i] - opbc_pkg::PHASE_W'(1);
                if (oper_cnt[i] > 1)
                    oper_cnt[i] = oper_cnt[i] - opbc_pkg::OPER_W'(1);
            end
            // scan in ascending order, a line may flip twice
            for (int i = 0; i < LINES; i++)
            begin
                if (phase_cnt[i] == 1 && line_md[i] == opbc_pkg::MODE_BLINK)
                begin
                    phase_cnt[i] = line_lvl[i] ? blink_lo[i] : blink_hi[i];
                    line_lvl[i]  = ~line_lvl[i];
                end
                if (oper_cnt[i] == 1)
                begin
                    line_lvl[i]  = ~line_lvl[i];
                    phase_cnt[i] = '0;
                    oper_cnt[i]  = '0;
                    line_md[i]   = opbc_pkg::MODE_SET;
                end
            end
        end
        else if (c < LINES)
        begin
            case (cmd.kind)
                opbc_pkg::REQ_SET, opbc_pkg::REQ_TOGGLE:
                begin
                    phase_cnt[c] = '0;
                    oper_cnt[c]  = '0;
                    line_md[c]   = opbc_pkg::MODE_SET;
                    line_lvl[c]  = (cmd.kind == opbc_pkg::REQ_SET) ? cmd.lvl : ~line_lvl[c];
                end
                opbc_pkg::REQ_PULSE:
                begin
                    oper_cnt[c]  = opbc_pkg::OPER_W'(ms_to_ticks(cmd.op_ms,
                                                                 opbc_pkg::OPER_LIM));
                    phase_cnt[c] = '0;
                    line_md[c]   = opbc_pkg::MODE_PULSE;
                    line_lvl[c]  = cmd.lvl;
                end
                opbc_pkg::REQ_BLINK:
                begin
                    blink_hi[c]  = opbc_pkg::PHASE_W'(ms_to_ticks(32'(cmd.hi_ms),
                                                                  opbc_pkg::PHASE_LIM));
                    blink_lo[c]  = opbc_pkg::PHASE_W'(ms_to_ticks(32'(cmd.lo_ms),
                                                                  opbc_pkg::PHASE_LIM));
                    phase_cnt[c] = blink_hi[c];
                    oper_cnt[c]  = (cmd.op_ms != 0) ?
                                   opbc_pkg::OPER_W'(ms_to_ticks(cmd.op_ms,
                                                                 opbc_pkg::OPER_LIM)) : '0;
                    line_md[c]   = opbc_pkg::MODE_BLINK;
                    line_lvl[c]  = 1'b1;
                end
                default: ;
            endcase
        end
        lv = '0;
        for (int i = 0; i < LINES && i < opbc_pkg::LEVELS_W; i++)
            lv[i] = line_lvl[i];
        return lv;
    endfunction

    // idle length: mostly short, a few long, none during calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random request, mostly ticks and short timers so lines expire often
    function automatic line_cmd_t random_cmd();
        line_cmd_t cmd;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)      cmd.kind = opbc_pkg::REQ_TICK;
        else if (sel < 54) cmd.kind = opbc_pkg::REQ_SET;
        else if (sel < 62) cmd.kind = opbc_pkg::REQ_TOGGLE;
        else if (sel < 78) cmd.kind = opbc_pkg::REQ_PULSE;
        else if (sel < 96) cmd.kind = opbc_pkg::REQ_BLINK;
        else               cmd.kind = opbc_pkg::req_code_t'($urandom_range(5, 7));
        cmd.chan  = opbc_pkg::CHAN_W'($urandom_range(0, LINES - 1));
        cmd.lvl   = 1'($urandom_range(0, 1));
        cmd.hi_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
        cmd.lo_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
        sel = $urandom_range(0, 11);
        if (sel == 0)      cmd.op_ms = $urandom;
        else if (sel < 3)  cmd.op_ms = '0;
        else               cmd.op_ms = 32'($urandom_range(0, 1500));
        return cmd;
    endfunction

    // present one request and wait for it to be taken
    task automatic drive_request(input line_cmd_t cmd, input logic fixed,
                                 input logic [opbc_pkg::LEVELS_W-1:0] want);
        int gap;
        logic [opbc_pkg::LEVELS_W-1:0] got;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= cmd.kind;
        req_ch.channel  <= cmd.chan;
        req_ch.level    <= cmd.lvl;
        req_ch.high_ms  <= cmd.hi_ms;
        req_ch.low_ms   <= cmd.lo_ms;
        req_ch.oper_ms  <= cmd.op_ms;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        got = apply_request(cmd);
        expected_levels.push_back(fixed ? want : got);
    endtask

    // stop sending until every expected response is back
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_levels.size() != 0);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // reset, asserted once
    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // request side
    initial
    begin : stimulus
        line_cmd_t cmd;
        errors     = 0;
        calm_phase = 1'b0;
        for (int i = 0; i < LINES; i++)
        begin
            line_lvl[i]  = 1'b0;
            line_md[i]   = opbc_pkg::MODE_SET;
            phase_cnt[i] = '0;
            oper_cnt[i]  = '0;
            blink_hi[i]  = '0;
            blink_lo[i]  = '0;
        end
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= opbc_pkg::REQ_TICK;
        req_ch.channel  <= '0;
        req_ch.level    <= 1'b0;
        req_ch.high_ms  <= '0;
        req_ch.low_ms   <= '0;
        req_ch.oper_ms  <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // directed table
        for (int i = 0; i < 25; i++)
            drive_request(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
        hold_until_drained();

        // random part, with calm stretches and periodic full drains
        for (int n = 0; n < 725; n++)
        begin
            if (n % 50 == 0) calm_phase = ($urandom_range(0, 3) == 0);
            if (n % 150 == 149) hold_until_drained();
            cmd = random_cmd();
            drive_request(cmd, 1'b0, '0);
        end
        hold_until_drained();
        repeat (50) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // response side ready with random stalls
    initial
    begin
        ready_hold = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (ready_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                ready_hold--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 4) == 0) ready_hold = pick_gap();
            end
        end
    end

    // compare each accepted response with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("levels: unexpected response, expected none, actual %h", rsp_ch.levels);
                errors++;
            end
            else
            begin
                want_levels = expected_levels.pop_front();
                if (rsp_ch.levels !== want_levels)
                begin
                    $error("levels mismatch: expected %h, actual %h", want_levels, rsp_ch.levels);
                    errors++;
                end
            end
        end
    end

endmodule

FILE: files.f
hdl/opbc_pkg.sv
hdl/opbc_if.sv
hdl/opbc_divider.sv
hdl/opbc_state_mem.sv
hdl/opbc_tick_logic.sv
hdl/output_pulse_blink_controller_core.sv
hdl/opbc_checker.sv
test/output_pulse_blink_controller_core_test.sv
